// ===== rtl/core/ftws_pkg.sv =====
package ftws_pkg;

    // Field widths
    localparam int TS_W = 64;
    localparam int MS_W = 32;

    // Default ring depth and counter frequency after reset
    localparam int          WINDOW_SIZE_DEF = 60;
    localparam logic [31:0] FREQ_RESET      = 32'd10000000;

    // ticks * 1000 fits in 74 bits, shifted up by 16 for Q16.16
    localparam int PROD_W = TS_W + 10;
    localparam int FRAC_W = 16;
    localparam int NUM_W  = PROD_W + FRAC_W;
    localparam int DCNT_W = $clog2(NUM_W);

    // Event kinds
    localparam logic OP_START = 1'b0;
    localparam logic OP_END   = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic start_latch;
        logic end_latch;
        logic mul_first;
        logic div_load_conv;
        logic div_load_mean;
        logic div_step;
        logic ring_write;
        logic scan_issue;
        logic out_load;
    } ftws_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_last;
        logic scan_last;
    } ftws_status_t;

endpackage

// ===== rtl/core/ftws_ctrl.sv =====
module ftws_ctrl
    import ftws_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    input  logic         s_op,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    input  ftws_status_t status,
    output ftws_cmd_t    cmd
);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_MUL1  = 10'b0000000010,
        ST_MUL2  = 10'b0000000100,
        ST_CDIV  = 10'b0000001000,
        ST_WRITE = 10'b0000010000,
        ST_SCAN  = 10'b0000100000,
        ST_FLUSH = 10'b0001000000,
        ST_MLOAD = 10'b0010000000,
        ST_MDIV  = 10'b0100000000,
        ST_EMIT  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    // Latch a frame-start word in idle, or sequence a frame-end word through convert, store, scan, mean and emit
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_op == OP_END) begin
                        cmd.end_latch = 1'b1;
                        state_next    = ST_MUL1;
                    end else begin
                        cmd.start_latch = 1'b1;
                    end
                end
            end
            ST_MUL1: begin
                cmd.mul_first = 1'b1;
                state_next    = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.div_load_conv = 1'b1;
                state_next        = ST_CDIV;
            end
            ST_CDIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.ring_write = 1'b1;
                state_next     = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                state_next = ST_MLOAD;
            end
            ST_MLOAD: begin
                cmd.div_load_mean = 1'b1;
                state_next        = ST_MDIV;
            end
            ST_MDIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result word until taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== rtl/core/ftws_dpath.sv =====
module ftws_dpath
    import ftws_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
)
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [31:0]       cfg_wr_data,
    input  logic [TS_W-1:0]   s_timestamp,
    input  ftws_cmd_t         cmd,
    output ftws_status_t      status,
    output logic [MS_W-1:0]   m_last_ms,
    output logic [MS_W-1:0]   m_mean_ms,
    output logic [MS_W-1:0]   m_min_ms,
    output logic [MS_W-1:0]   m_max_ms
);

    localparam int AW    = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CW    = $clog2(WINDOW_SIZE + 1);
    localparam int SUM_W = MS_W + CW;

    // Configuration and event registers
    logic [31:0]        freq_reg;
    logic [TS_W-1:0]    start_reg;
    logic [TS_W-1:0]    elapsed_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  prod_ext;

    // Shared restoring divider
    logic [NUM_W-1:0]   num_reg;
    logic [31:0]        divisor_reg;
    logic [31:0]        rem_reg;
    logic [MS_W-1:0]    quo_reg;
    logic               ovf_reg;
    logic [DCNT_W-1:0]  dcnt_reg;
    logic [32:0]        trial;
    logic               trial_ge;

    // Ring and scan
    logic [MS_W-1:0]    ring_mem [WINDOW_SIZE];
    logic [AW-1:0]      slot_reg;
    logic [CW-1:0]      filled_reg;
    logic [AW-1:0]      scan_idx_reg;
    logic [MS_W-1:0]    rd_data_reg;
    logic               acc_en_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [MS_W-1:0]    min_reg;
    logic [MS_W-1:0]    max_reg;
    logic [MS_W-1:0]    ms_reg;
    logic [MS_W-1:0]    ms_conv;

    // Result payload
    logic [MS_W-1:0]    last_out_reg;
    logic [MS_W-1:0]    mean_out_reg;
    logic [MS_W-1:0]    min_out_reg;
    logic [MS_W-1:0]    max_out_reg;

    assign prod_ext = PROD_W'(elapsed_reg);
    assign trial    = {rem_reg, num_reg[NUM_W-1]};
    assign trial_ge = (trial >= {1'b0, divisor_reg});

    assign status.div_last  = (dcnt_reg == '0);
    assign status.scan_last = (CW'(scan_idx_reg) == filled_reg - CW'(1));

    // Zero frequency gives zero; quotient bits past 32 saturate
    always_comb begin
        if (freq_reg == '0) begin
            ms_conv = '0;
        end else if (ovf_reg) begin
            ms_conv = '1;
        end else begin
            ms_conv = quo_reg;
        end
    end

    // Hold the counter frequency and the latched start stamp
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_reg  <= FREQ_RESET;
            start_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                freq_reg <= cfg_wr_data;
            end
            if (cmd.start_latch) begin
                start_reg <= s_timestamp;
            end
        end
    end

    // Elapsed ticks, and the first shift-and-subtract step of times 1000; the divider load finishes it
    always_ff @(posedge aclk) begin
        if (cmd.end_latch) begin
            elapsed_reg <= s_timestamp - start_reg;
        end
        if (cmd.mul_first) begin
            prod_reg <= (prod_ext << 10) - (prod_ext << 4);
        end
    end

    // Load and advance the divider one quotient bit a cycle
    always_ff @(posedge aclk) begin
        if (cmd.div_load_conv) begin
            num_reg     <= {prod_reg - (prod_ext << 3), {FRAC_W{1'b0}}};
            divisor_reg <= freq_reg;
            rem_reg     <= '0;
            quo_reg     <= '0;
            ovf_reg     <= 1'b0;
            dcnt_reg    <= DCNT_W'(NUM_W - 1);
        end else if (cmd.div_load_mean) begin
            num_reg     <= {sum_reg, {(NUM_W - SUM_W){1'b0}}};
            divisor_reg <= 32'(filled_reg);
            rem_reg     <= '0;
            quo_reg     <= '0;
            ovf_reg     <= 1'b0;
            dcnt_reg    <= DCNT_W'(SUM_W - 1);
        end else if (cmd.div_step) begin
            num_reg  <= num_reg << 1;
            rem_reg  <= trial_ge ? 32'(trial - {1'b0, divisor_reg}) : trial[31:0];
            quo_reg  <= {quo_reg[MS_W-2:0], trial_ge};
            ovf_reg  <= ovf_reg | quo_reg[MS_W-1];
            dcnt_reg <= dcnt_reg - DCNT_W'(1);
        end
    end

    // Advance the write slot and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg   <= '0;
            filled_reg <= '0;
            acc_en_reg <= 1'b0;
        end else begin
            acc_en_reg <= cmd.scan_issue;
            if (cmd.ring_write) begin
                if (32'(slot_reg) >= WINDOW_SIZE - 1) begin
                    slot_reg <= '0;
                end else begin
                    slot_reg <= slot_reg + AW'(1);
                end
                if (32'(filled_reg) < WINDOW_SIZE) begin
                    filled_reg <= filled_reg + CW'(1);
                end
            end
        end
    end

    // Ring memory: write the new frame time, read one slot a cycle
    always_ff @(posedge aclk) begin
        if (cmd.ring_write) begin
            ring_mem[slot_reg] <= ms_conv;
        end
        if (cmd.scan_issue) begin
            rd_data_reg <= ring_mem[scan_idx_reg];
        end
    end

    // Scan the filled slots for sum, minimum and maximum
    always_ff @(posedge aclk) begin
        if (cmd.ring_write) begin
            ms_reg       <= ms_conv;
            min_reg      <= ms_conv;
            max_reg      <= ms_conv;
            sum_reg      <= '0;
            scan_idx_reg <= '0;
        end else begin
            if (cmd.scan_issue) begin
                scan_idx_reg <= scan_idx_reg + AW'(1);
            end
            if (acc_en_reg) begin
                sum_reg <= sum_reg + SUM_W'(rd_data_reg);
                if (rd_data_reg < min_reg) begin
                    min_reg <= rd_data_reg;
                end
                if (rd_data_reg > max_reg) begin
                    max_reg <= rd_data_reg;
                end
            end
        end
    end

    // Load the result word
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            last_out_reg <= ms_reg;
            mean_out_reg <= quo_reg;
            min_out_reg  <= min_reg;
            max_out_reg  <= max_reg;
        end
    end

    assign m_last_ms = last_out_reg;
    assign m_mean_ms = mean_out_reg;
    assign m_min_ms  = min_out_reg;
    assign m_max_ms  = max_out_reg;

endmodule

// ===== rtl/core/frame_time_window_stats_unit.sv =====
// Frame-time window statistics. A frame-start word (op 0) latches its timestamp and
// gives no result. A frame-end word (op 1) converts the ticks since the latched
// start to milliseconds in unsigned Q16.16 using cfg_wr_data's frequency (zero gives 0,
// overflow saturates to all ones), stores it in a ring of the last WINDOW_SIZE frames and
// returns last, mean, minimum and maximum over the filled slots. A frame-end word runs a
// bit-serial divider for the conversion, scans the filled slots through the single ring
// read port at one slot per cycle, and runs the same divider for the mean. One word is
// worked at a time; the next word is taken while the result still waits in its register.
module frame_time_window_stats_unit
    import ftws_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
)
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [31:0]       cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_op,
    input  logic [TS_W-1:0]   s_timestamp,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [MS_W-1:0]   m_last_ms,
    output logic [MS_W-1:0]   m_mean_ms,
    output logic [MS_W-1:0]   m_min_ms,
    output logic [MS_W-1:0]   m_max_ms
);

    ftws_cmd_t    cmd;
    ftws_status_t status;

    ftws_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ftws_dpath #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_timestamp (s_timestamp),
        .cmd         (cmd),
        .status      (status),
        .m_last_ms   (m_last_ms),
        .m_mean_ms   (m_mean_ms),
        .m_min_ms    (m_min_ms),
        .m_max_ms    (m_max_ms)
    );

endmodule

// ===== dv/frame_stats_checker.sv =====
module frame_stats_checker
    import ftws_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
)
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [31:0]     cfg_wr_data,
    input  logic            s_valid,
    input  logic            s_ready,
    input  logic            s_op,
    input  logic [TS_W-1:0] s_timestamp,
    input  logic            m_valid,
    input  logic            m_ready,
    input  logic [MS_W-1:0] m_last_ms,
    input  logic [MS_W-1:0] m_mean_ms,
    input  logic [MS_W-1:0] m_min_ms,
    input  logic [MS_W-1:0] m_max_ms,
    output int              err_count,
    output int              pending
);

    // Q16.16 milliseconds in one second
    localparam logic [127:0]    Q16_MS_PER_SEC = 128'd1000 << FRAC_W;
    localparam logic [MS_W-1:0] MS_SAT         = '1;

    typedef struct packed {
        logic [MS_W-1:0] last_ms;
        logic [MS_W-1:0] mean_ms;
        logic [MS_W-1:0] min_ms;
        logic [MS_W-1:0] max_ms;
    } frame_stats_t;

    logic [31:0]     freq_hz;
    logic [TS_W-1:0] frame_open_stamp;
    logic [MS_W-1:0] frame_ring [WINDOW_SIZE];
    int unsigned     ring_slot;
    int unsigned     ring_fill;
    frame_stats_t    stats_q [$];
    int              fail_cnt = 0;

    // Exact tick-to-millisecond conversion, saturated to the field maximum
    function automatic logic [MS_W-1:0] ticks_to_q16_ms(logic [TS_W-1:0] ticks,
                                                        logic [31:0] freq);
        logic [127:0] quot;
        if (freq == '0)
            return '0;
        quot = (128'(ticks) * Q16_MS_PER_SEC) / 128'(freq);
        return (quot > 128'(MS_SAT)) ? MS_SAT : quot[MS_W-1:0];
    endfunction

    // Push one frame time into the ring and scan the filled slots
    function automatic frame_stats_t log_frame_end(logic [MS_W-1:0] ms);
        frame_stats_t st;
        logic [63:0]  sum;
        sum = '0;
        frame_ring[ring_slot] = ms;
        ring_slot = (ring_slot + 1 == WINDOW_SIZE) ? 0 : ring_slot + 1;
        if (ring_fill < WINDOW_SIZE)
            ring_fill++;
        st.last_ms = ms;
        st.min_ms  = ms;
        st.max_ms  = ms;
        for (int i = 0; i < ring_fill; i++) begin
            sum += frame_ring[i];
            if (frame_ring[i] < st.min_ms)
                st.min_ms = frame_ring[i];
            if (frame_ring[i] > st.max_ms)
                st.max_ms = frame_ring[i];
        end
        st.mean_ms = MS_W'(sum / ring_fill);
        return st;
    endfunction

    always @(posedge aclk) begin : watch
        frame_stats_t want;
        if (!aresetn) begin
            freq_hz          = FREQ_RESET;
            frame_open_stamp = '0;
            ring_slot        = 0;
            ring_fill        = 0;
            stats_q.delete();
        end else begin
            // retire a result word against the oldest expectation
            if (m_valid && m_ready) begin
                if (stats_q.size() == 0) begin
                    if (fail_cnt < 10)
                        $display("%0t: result word with nothing pending: last %h mean %h min %h max %h",
                                 $realtime, m_last_ms, m_mean_ms, m_min_ms, m_max_ms);
                    fail_cnt++;
                end else begin
                    want = stats_q.pop_front();
                    if (m_last_ms !== want.last_ms || m_mean_ms !== want.mean_ms ||
                        m_min_ms !== want.min_ms || m_max_ms !== want.max_ms) begin
                        if (fail_cnt < 10) begin
                            $display("%0t: stats mismatch", $realtime);
                            $display("    last exp %h got %h", want.last_ms, m_last_ms);
                            $display("    mean exp %h got %h", want.mean_ms, m_mean_ms);
                            $display("    min  exp %h got %h", want.min_ms, m_min_ms);
                            $display("    max  exp %h got %h", want.max_ms, m_max_ms);
                        end
                        fail_cnt++;
                    end
                end
            end
            // track the frequency register
            if (cfg_wr_en)
                freq_hz = cfg_wr_data;
            // latch a start, or predict the stats of an end
            if (s_valid && s_ready) begin
                if (s_op == OP_END)
                    stats_q.push_back(log_frame_end(
                        ticks_to_q16_ms(s_timestamp - frame_open_stamp, freq_hz)));
                else
                    frame_open_stamp = s_timestamp;
            end
        end
        err_count <= fail_cnt;
        pending   <= stats_q.size();
    end

endmodule

// ===== dv/frame_time_window_stats_unit_tb.sv =====
module frame_time_window_stats_unit_tb;
    import ftws_pkg::*;

    localparam int RANDOM_PHASE  = 260;
    localparam int HOLD_AFTER    = 400;
    localparam int HOLD_CYCLES   = 3000;
    localparam int SETTLE_CYCLES = 300;
    localparam int CYCLE_LIMIT   = 6_000_000;

    logic            aclk        = 1'b0;
    logic            aresetn     = 1'b0;
    logic            cfg_wr_en   = 1'b0;
    logic [31:0]     cfg_wr_data = '0;
    logic            s_valid     = 1'b0;
    logic            s_ready;
    logic            s_op        = OP_START;
    logic [TS_W-1:0] s_timestamp = '0;
    logic            m_valid;
    logic            m_ready     = 1'b0;
    logic [MS_W-1:0] m_last_ms;
    logic [MS_W-1:0] m_mean_ms;
    logic [MS_W-1:0] m_min_ms;
    logic [MS_W-1:0] m_max_ms;
    int              err_count;
    int              pending;

    int              words_sent = 0;
    logic [31:0]     cur_freq   = FREQ_RESET;
    logic [TS_W-1:0] last_start = '0;
    bit              no_gaps    = 1'b0;

    frame_time_window_stats_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_timestamp (s_timestamp),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_last_ms   (m_last_ms),
        .m_mean_ms   (m_mean_ms),
        .m_min_ms    (m_min_ms),
        .m_max_ms    (m_max_ms)
    );

    frame_stats_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_timestamp (s_timestamp),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_last_ms   (m_last_ms),
        .m_mean_ms   (m_mean_ms),
        .m_min_ms    (m_min_ms),
        .m_max_ms    (m_max_ms),
        .err_count   (err_count),
        .pending     (pending)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Offer one word after a random gap and hold it until taken
    task automatic send_word(input logic op, input logic [TS_W-1:0] ts);
        int gap;
        int pick;
        pick = $urandom_range(0, 99);
        if (no_gaps || pick < 55)
            gap = 0;
        else if (pick < 88)
            gap = $urandom_range(1, 4);
        else if (pick < 98)
            gap = $urandom_range(5, 30);
        else
            gap = $urandom_range(100, 400);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_op        <= op;
        s_timestamp <= ts;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        if (op == OP_START)
            last_start = ts;
    endtask

    task automatic set_freq(input logic [31:0] hz);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= hz;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_freq = hz;
    endtask

    // Drop valid, drain every pending result, then idle before the next phase
    task automatic settle_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Frame length in ticks: mostly short, some near or past saturation
    function automatic logic [TS_W-1:0] frame_ticks(logic [31:0] freq);
        logic [63:0] base;
        logic [63:0] sat_ticks;
        int          pick;
        base      = (freq == '0) ? 64'd10_000_000 : 64'(freq);
        sat_ticks = (base << FRAC_W) / 1000;
        pick      = $urandom_range(0, 99);
        if (pick < 50)
            return (base * $urandom_range(0, 255)) >> 8;
        else if (pick < 72)
            return base * $urandom_range(0, 70) + ($urandom % base);
        else if (pick < 82)
            return sat_ticks - 3 + $urandom_range(0, 6);
        else if (pick < 92)
            return {$urandom, $urandom};
        else
            return $urandom_range(0, 3);
    endfunction

    // Mostly well-formed start/end pairs, the rest stray starts and ends
    task automatic random_frames(input int count);
        int              first;
        int              pick;
        logic [TS_W-1:0] t0;
        first = words_sent;
        while (words_sent - first < count) begin
            if ($urandom_range(0, 49) == 0)
                no_gaps = !no_gaps;
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                t0 = {$urandom, $urandom};
                send_word(OP_START, t0);
                send_word(OP_END, t0 + frame_ticks(cur_freq));
            end else if (pick < 87) begin
                send_word(OP_START, {$urandom, $urandom});
            end else if (pick < 94) begin
                send_word(OP_END, last_start + frame_ticks(cur_freq));
            end else begin
                send_word(OP_END, {$urandom, $urandom});
            end
        end
        no_gaps = 1'b0;
    endtask

    // Result side: random stalls, one long hold-off to back up the block
    initial begin : result_sink
        int hi_len;
        int lo_len;
        int pick;
        bit held;
        held = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (!held && words_sent >= HOLD_AFTER) begin
                held = 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            hi_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                 : $urandom_range(1, 12);
            m_ready <= 1'b1;
            repeat (hi_len) @(posedge aclk);
            pick = $urandom_range(0, 99);
            if (pick < 80)
                lo_len = $urandom_range(1, 3);
            else if (pick < 96)
                lo_len = $urandom_range(4, 20);
            else
                lo_len = $urandom_range(50, 300);
            m_ready <= 1'b0;
            repeat (lo_len) @(posedge aclk);
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("frame_time_window_stats_unit_tb: done, errors");
        $finish;
    end

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed corners at the reset frequency
        send_word(OP_END,   64'd10_000_000);              // end with no start seen
        send_word(OP_START, 64'h0123_4567_89AB_CDEF);
        send_word(OP_END,   64'h0123_4567_89AB_CDEF);     // zero-length frame
        send_word(OP_START, '1);
        send_word(OP_END,   '0);                          // counter wraps by one tick
        send_word(OP_START, 64'd1000);
        send_word(OP_END,   64'd999);                     // end below start saturates
        send_word(OP_START, '0);
        send_word(OP_END,   64'd655_359_999);             // just under saturation
        send_word(OP_END,   64'd655_360_000);             // repeated end, saturates
        send_word(OP_START, 64'd5);
        send_word(OP_START, 64'hAAAA_AAAA_AAAA_AAAA);     // later start replaces
        send_word(OP_END,   64'hAAAA_AAAA_AAAA_AAAA + 64'd10_000_000);
        send_word(OP_START, 64'h5555_5555_5555_5555);
        send_word(OP_END,   64'h5555_5555_5555_5556);

        // zero frequency still records a zero frame time
        settle_idle();
        set_freq('0);
        send_word(OP_START, '0);
        send_word(OP_END,   '1);

        // top frequency
        settle_idle();
        set_freq('1);
        send_word(OP_START, '0);
        send_word(OP_END,   64'hFFFF_FFFF);
        send_word(OP_END,   '1);

        // one hertz: 65 ticks fit, 66 saturate
        settle_idle();
        set_freq(32'd1);
        send_word(OP_START, '0);
        send_word(OP_END,   64'd65);
        send_word(OP_END,   64'd66);

        // random phases across frequencies
        settle_idle();
        set_freq('1);
        random_frames(RANDOM_PHASE);
        settle_idle();
        set_freq($urandom);
        random_frames(RANDOM_PHASE);
        settle_idle();
        set_freq('0);
        random_frames(RANDOM_PHASE);
        settle_idle();
        set_freq(FREQ_RESET);
        random_frames(RANDOM_PHASE);
        settle_idle();
        set_freq(32'd1000);
        random_frames(RANDOM_PHASE);
        settle_idle();
        set_freq($urandom_range(1, 32'h00FF_FFFF));
        random_frames(RANDOM_PHASE);
        settle_idle();

        if (err_count == 0)
            $display("frame_time_window_stats_unit_tb: done, clean");
        else
            $display("frame_time_window_stats_unit_tb: done, errors");
        $finish;
    end

endmodule
